### sv/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants for the month calendar grid
// Field widths, cell kinds, the page descriptor and calendar tables.
// ----------------------------------------------------------------------------
package mcg_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int KIND_W  = 2;

	localparam int CELLS  = 42;
	localparam int CELL_W = 6;

	// floor(q / 25) == (q * RECIP_25) >> RECIP_25_SH, exact for q < 4681
	localparam logic [11:0] RECIP_25    = 12'd2622;
	localparam int          RECIP_25_SH = 16;
	// floor(x / 7) == (x * RECIP_7) >> RECIP_7_SH, exact for x < 43690
	localparam logic [15:0] RECIP_7     = 16'd37450;
	localparam int          RECIP_7_SH  = 18;

	localparam logic [MONTH_W-1:0] JAN = 4'd1;
	localparam logic [MONTH_W-1:0] FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MAR = 4'd3;
	localparam logic [MONTH_W-1:0] DEC = 4'd12;

	typedef enum logic [KIND_W-1:0] {
		KIND_PREV = 2'd0,
		KIND_CUR  = 2'd1,
		KIND_NEXT = 2'd2
	} cell_kind_t;

	// one page worth of layout, front to back
	typedef struct packed {
		logic [2:0]       head;      // weekday of the 1st, 0 = Sunday
		logic [DAY_W-1:0] len;       // days in given month
		logic [DAY_W-1:0] prev_len;  // days in previous month
		logic [DAY_W-1:0] today;
	} page_desc_t;

	// days before the first of month m in a common year
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                                input logic leap);
		logic [DAY_W-1:0] d;
		case (m)
			4'd2:                      d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

### sv/mcg_date_if.sv
// ----------------------------------------------------------------------------
// mcg_date_if: request channel carrying one year/month/today beat
// Valid/ready handshake with source and sink modports.
// ----------------------------------------------------------------------------
interface mcg_date_if;
	logic                          valid;
	logic                          ready;
	logic [mcg_pkg::YEAR_W-1:0]    year;
	logic [mcg_pkg::MONTH_W-1:0]   month;
	logic [mcg_pkg::DAY_W-1:0]     today_day;

	modport source (output valid, output year, output month, output today_day, input ready);
	modport sink   (input valid, input year, input month, input today_day, output ready);
endinterface

### sv/mcg_page_if.sv
// ----------------------------------------------------------------------------
// mcg_page_if: result channel carrying one calendar cell per beat
// Valid/ready handshake with source and sink modports.
// ----------------------------------------------------------------------------
interface mcg_page_if;
	logic                         valid;
	logic                         ready;
	logic [mcg_pkg::DAY_W-1:0]    day_number;
	logic [mcg_pkg::KIND_W-1:0]   cell_kind;
	logic                         is_today;
	logic                         last_cell;

	modport source (output valid, output day_number, output cell_kind, output is_today,
	                output last_cell, input ready);
	modport sink   (input valid, input day_number, input cell_kind, input is_today,
	                input last_cell, output ready);
endinterface

### sv/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front: page layout pipeline
// Four stages turn year/month/today into weekday of the 1st and month lengths.
// ----------------------------------------------------------------------------
module mcg_front (
	input  logic                clk,
	input  logic                arst_n,
	mcg_date_if.sink            date,
	output logic                push_valid,
	input  logic                push_ready,
	output mcg_pkg::page_desc_t push_desc
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 0: clamp inputs
	logic [mcg_pkg::YEAR_W-1:0]  y_c;
	logic [mcg_pkg::MONTH_W-1:0] m_c;

	assign y_c = (date.year == '0) ? 14'd1 : date.year;
	assign m_c = (date.month == '0) ? mcg_pkg::JAN :
	             (date.month > mcg_pkg::DEC) ? mcg_pkg::DEC : date.month;

	assign en         = !v_s4 || push_ready;
	assign date.ready = en;

	// stage 1
	logic [13:0]                 p_s1;
	logic [11:0]                 yq_s1;
	logic [3:0]                  ylo_s1;
	logic [mcg_pkg::MONTH_W-1:0] m_s1;
	logic [mcg_pkg::DAY_W-1:0]   today_s1;

	// stage 2
	logic [13:0]                 p_s2;
	logic [11:0]                 yq_s2;
	logic [3:0]                  ylo_s2;
	logic [mcg_pkg::MONTH_W-1:0] m_s2;
	logic [mcg_pkg::DAY_W-1:0]   today_s2;
	logic [7:0]                  p100_s2;
	logic [5:0]                  p400_s2;
	logic [7:0]                  yc_s2;

	logic [23:0] prod_p100, prod_p400, prod_yc;

	assign prod_p100 = 24'(p_s1[13:2]) * 24'(mcg_pkg::RECIP_25);
	assign prod_p400 = 24'(p_s1[13:4]) * 24'(mcg_pkg::RECIP_25);
	assign prod_yc   = 24'(yq_s1) * 24'(mcg_pkg::RECIP_25);

	// stage 3
	logic [14:0]               x_s3;
	logic [mcg_pkg::DAY_W-1:0] len_s3, plen_s3, today_s3;

	logic [11:0]               yc25;
	logic                      div25, leap;
	logic [8:0]                doy;
	logic [15:0]               x_sum;
	logic [mcg_pkg::MONTH_W-1:0] pm;

	assign yc25  = {yc_s2, 4'b0} + {1'b0, yc_s2, 3'b0} + 12'(yc_s2);
	assign div25 = (yc25 == yq_s2);
	// leap: by 4, and either not by 100 or by 400 (by 100 and 16)
	assign leap  = (ylo_s2[1:0] == 2'b00) && (!div25 || (ylo_s2[3:2] == 2'b00));
	assign doy   = mcg_pkg::cum_days(m_s2) + 9'((leap && (m_s2 > mcg_pkg::FEB)) ? 1 : 0)
	               + 9'd1;
	assign x_sum = 16'(p_s2) + 16'(p_s2[13:2]) - 16'(p100_s2) + 16'(p400_s2) + 16'(doy);
	assign pm    = (m_s2 == mcg_pkg::JAN) ? mcg_pkg::DEC : m_s2 - 4'd1;

	// stage 4
	logic [14:0]               x_s4;
	logic [11:0]               q7_s4;
	logic [mcg_pkg::DAY_W-1:0] len_s4, plen_s4, today_s4;

	logic [31:0] prod_q7;
	logic [14:0] q7x7;

	assign prod_q7 = 32'(x_s3) * 32'(mcg_pkg::RECIP_7);
	assign q7x7    = {q7_s4, 3'b0} - 15'(q7_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= date.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= y_c - 14'd1;
			yq_s1    <= y_c[13:2];
			ylo_s1   <= y_c[3:0];
			m_s1     <= m_c;
			today_s1 <= date.today_day;

			p_s2     <= p_s1;
			yq_s2    <= yq_s1;
			ylo_s2   <= ylo_s1;
			m_s2     <= m_s1;
			today_s2 <= today_s1;
			p100_s2  <= prod_p100[mcg_pkg::RECIP_25_SH +: 8];
			p400_s2  <= prod_p400[mcg_pkg::RECIP_25_SH +: 6];
			yc_s2    <= prod_yc[mcg_pkg::RECIP_25_SH +: 8];

			x_s3     <= x_sum[14:0];
			len_s3   <= mcg_pkg::month_days(m_s2, leap);
			plen_s3  <= mcg_pkg::month_days(pm, leap);
			today_s3 <= today_s2;

			x_s4     <= x_s3;
			q7_s4    <= prod_q7[mcg_pkg::RECIP_7_SH +: 12];
			len_s4   <= len_s3;
			plen_s4  <= plen_s3;
			today_s4 <= today_s3;
		end
	end

	logic [14:0] rem7;
	assign rem7 = x_s4 - q7x7;

	assign push_valid         = v_s4;
	assign push_desc.head     = rem7[2:0];
	assign push_desc.len      = len_s4;
	assign push_desc.prev_len = plen_s4;
	assign push_desc.today    = today_s4;

endmodule

### sv/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue: two-entry descriptor queue
// Decouples the layout pipeline from the cell sequencer.
// ----------------------------------------------------------------------------
module mcg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mcg_pkg::page_desc_t push_desc,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mcg_pkg::page_desc_t pop_desc
);

	mcg_pkg::page_desc_t mem_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          count_q;
	logic                push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_desc   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count overflow");
`endif

endmodule

### sv/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back: cell sequencer
// Walks the 42 cells of a page, one per beat, into an output register.
// ----------------------------------------------------------------------------
module mcg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  mcg_pkg::page_desc_t pop_desc,
	mcg_page_if.source          page
);

	logic                        busy_q;
	logic [mcg_pkg::CELL_W-1:0]  k_q;
	mcg_pkg::cell_kind_t         kind_q;
	logic [mcg_pkg::DAY_W-1:0]   day_q, len_q, plen_q, today_q;

	logic                        ovalid_q;
	logic [mcg_pkg::DAY_W-1:0]   oday_q;
	mcg_pkg::cell_kind_t         okind_q;
	logic                        otoday_q, olast_q;

	logic adv, last, pop;

	assign adv       = busy_q && (!ovalid_q || page.ready);
	assign last      = (k_q == mcg_pkg::CELL_W'(mcg_pkg::CELLS - 1));
	assign pop       = pop_valid && (!busy_q || (adv && last));
	assign pop_ready = !busy_q || (adv && last);

	// walk to the next cell
	mcg_pkg::cell_kind_t       kind_nx;
	logic [mcg_pkg::DAY_W-1:0] day_nx;

	always_comb begin
		kind_nx = kind_q;
		day_nx  = day_q + 5'd1;
		if (kind_q == mcg_pkg::KIND_PREV && day_q == plen_q) begin
			kind_nx = mcg_pkg::KIND_CUR;
			day_nx  = 5'd1;
		end else if (kind_q == mcg_pkg::KIND_CUR && day_q == len_q) begin
			kind_nx = mcg_pkg::KIND_NEXT;
			day_nx  = 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (adv && last)
				busy_q <= 1'b0;
			if (adv)
				ovalid_q <= 1'b1;
			else if (page.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oday_q   <= day_q;
			okind_q  <= kind_q;
			otoday_q <= (kind_q == mcg_pkg::KIND_CUR) && (day_q == today_q);
			olast_q  <= last;
		end
		if (pop) begin
			k_q     <= '0;
			len_q   <= pop_desc.len;
			plen_q  <= pop_desc.prev_len;
			today_q <= pop_desc.today;
			if (pop_desc.head == 3'd0) begin
				kind_q <= mcg_pkg::KIND_CUR;
				day_q  <= 5'd1;
			end else begin
				kind_q <= mcg_pkg::KIND_PREV;
				day_q  <= pop_desc.prev_len - 5'(pop_desc.head) + 5'd1;
			end
		end else if (adv) begin
			k_q    <= k_q + 6'd1;
			kind_q <= kind_nx;
			day_q  <= day_nx;
		end
	end

	assign page.valid      = ovalid_q;
	assign page.day_number = oday_q;
	assign page.cell_kind  = okind_q;
	assign page.is_today   = otoday_q;
	assign page.last_cell  = olast_q;

`ifndef SYNTHESIS
	a_today_cur: assert property (@(posedge clk) disable iff (!arst_n)
		page.valid && page.is_today |-> page.cell_kind == mcg_pkg::KIND_CUR)
		else $error("today mark outside given month");
	a_last_next: assert property (@(posedge clk) disable iff (!arst_n)
		page.valid && page.last_cell |-> page.cell_kind == mcg_pkg::KIND_NEXT)
		else $error("last cell not in next month");
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last |=> page.valid && page.last_cell)
		else $error("last cell lost");
`endif

endmodule

### sv/month_calendar_grid_top.sv
// ----------------------------------------------------------------------------
// month_calendar_grid_top: six-week Sunday-first calendar page generator
// Front layout pipeline, descriptor queue and cell sequencer.
// ----------------------------------------------------------------------------
// Each date beat (year, month, today_day) yields 42 page beats, one cell per
// cycle unless page.ready stalls it, Sunday first: the closing days of the
// previous month, the days of the given month (is_today set on the matching
// day), then days 1, 2, ... of the next month, with last_cell marking the
// 42nd. The cell sequencer's counter walks the page and rolls straight into
// the next page with no gap when its descriptor is already queued. A
// four-stage layout pipeline (day count since year 1 via reciprocal
// multiplies, leap rule, mod 7) feeds a two-entry queue, so new dates keep
// being taken while a page is still being drained. Year 0 reads as year 1,
// month 0 as January and months above 12 as December; a today_day of 0 or
// past the month end marks no cell. No configuration, no state beyond reset.
// ----------------------------------------------------------------------------
module month_calendar_grid_top (
	input  logic       clk,
	input  logic       arst_n,
	mcg_date_if.sink   date,
	mcg_page_if.source page
);

	// layout pipeline -> queue
	logic                push_valid, push_ready;
	mcg_pkg::page_desc_t push_desc;

	// queue -> cell sequencer
	logic                pop_valid, pop_ready;
	mcg_pkg::page_desc_t pop_desc;

	mcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.date       (date),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	mcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	mcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.page      (page)
	);

endmodule
